// ===== hdl/ntt_pkg.sv =====
// Shared constants, types and elaboration-time tables for the NTT unit.
package ntt_pkg;

  localparam int MAX_LOG_N = 10;
  localparam int ADDR_W    = MAX_LOG_N;
  localparam int DEPTH     = 1 << MAX_LOG_N;
  localparam int CNT_W     = ADDR_W + 1;
  localparam int LG_W      = $clog2(MAX_LOG_N + 2);
  localparam int DATA_W    = 30;
  localparam int INDEX_W   = 10;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 4;

  localparam logic [DATA_W-1:0] PRIME = DATA_W'(998244353);
  localparam logic [63:0]       GEN   = 64'd3;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_SIZE  = 1'b1;

  typedef logic [MAX_LOG_N:0][DATA_W-1:0] tbl_t;

  // Elaboration only: modular power with 64-bit intermediates.
  function automatic logic [DATA_W-1:0] pow_c(logic [63:0] base, logic [63:0] e);
    logic [63:0] acc;
    logic [63:0] b;
    logic [63:0] x;
    acc = 64'd1;
    b   = base % 64'(PRIME);
    x   = e;
    for (int k = 0; k < 64; k++) begin
      if (x[0]) acc = (acc * b) % 64'(PRIME);
      b = (b * b) % 64'(PRIME);
      x = x >> 1;
    end
    return acc[DATA_W-1:0];
  endfunction

  // Entry u: root of unity of order 2^u.
  function automatic tbl_t roots_init();
    tbl_t t;
    for (int u = 0; u <= MAX_LOG_N; u++)
      t[u] = pow_c(GEN, (64'(PRIME) - 64'd1) >> u);
    return t;
  endfunction

  // Entry k: inverse of 2^k.
  function automatic tbl_t inv_init();
    tbl_t t;
    for (int k = 0; k <= MAX_LOG_N; k++)
      t[k] = pow_c(64'd1 << k, 64'(PRIME) - 64'd2);
    return t;
  endfunction

endpackage

// ===== hdl/ntt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ntt_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ntt_mulmod.sv =====
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
module ntt_mulmod
  import ntt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] op_a,
  input  logic [DATA_W-1:0] op_b,
  output logic              busy,
  output logic              done,
  output logic [DATA_W-1:0] result
);

  localparam int STEP_W = $clog2(DATA_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0] a_r, a_nxt;
  logic [DATA_W-1:0] b_r, b_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W:0]   dbl;
  logic [DATA_W:0]   dbl_red;
  logic [DATA_W:0]   sum;
  logic [DATA_W:0]   sum_red;

  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, PRIME}) ? dbl - {1'b0, PRIME} : dbl;
    sum     = dbl_red + (b_r[DATA_W-1] ? {1'b0, a_r} : '0);
    sum_red = (sum >= {1'b0, PRIME}) ? sum - {1'b0, PRIME} : sum;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(DATA_W);
      a_nxt    = op_a;
      b_nxt    = op_b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = sum_red[DATA_W-1:0];
      b_nxt   = {b_r[DATA_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = acc_r;

endmodule

// ===== hdl/ntt_mod_998244353_unit.sv =====
// NTT unit top level: element memory, run sequencer and request/result ports.
//
// Input requests carry an operation, an index and a value. A load writes one
// residue (reduced mod 998244353) into the 1024-entry element memory and
// gives no result. A read returns the element through the memory's read
// register and the result register, with is_done low. A run transforms
// elements 0..n-1 in place (n from the log_size register, direction from the
// direction register) and then gives one result with data zero and is_done
// high. Operation code 3 is dropped. Loads are taken one per cycle while the
// sequencer is idle, no read is pending and no result is stalled; a read
// stalls the input while the memory read completes, so no request follows a
// read directly. A run stalls the input until it ends: each butterfly takes
// two reads, a pass through the bit-serial modular multiplier and two writes,
// and each twiddle update a further multiplier pass, skipped after the last
// butterfly of a group; every swap in the permutation passes takes two reads
// and two writes; inverse scaling reads, multiplies and rewrites each element.
// A held stall on the result port keeps the result register full and the
// input side stalls every request until the result is taken.
// Reset (synchronous, active low) returns the registers to forward, log
// size 10; the element memory is not cleared and must be loaded before use.
module ntt_mod_998244353_unit
  import ntt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [INDEX_W-1:0]   in_index,
  input  logic [DATA_W-1:0]    in_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    out_data,
  output logic                 out_is_done
);

  localparam tbl_t ROOTS = roots_init();
  localparam tbl_t INV_N = inv_init();

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_NEXT = 9'b000000010,
    ST_RD_A = 9'b000000100,
    ST_RD_B = 9'b000001000,
    ST_GET  = 9'b000010000,
    ST_MUL  = 9'b000100000,
    ST_WR_A = 9'b001000000,
    ST_WR_B = 9'b010000000,
    ST_TW   = 9'b100000000
  } state_t;

  typedef enum logic [3:0] {
    PH_BITREV = 4'b0001,
    PH_BFLY   = 4'b0010,
    PH_FLIP   = 4'b0100,
    PH_SCALE  = 4'b1000
  } phase_t;

  state_t            state_r, state_nxt;
  phase_t            ph_r, ph_nxt;
  logic              dir_r, dir_nxt;
  logic [CFG_W-1:0]  lsz_r, lsz_nxt;
  logic [LG_W-1:0]   lg_r, lg_nxt;
  logic [LG_W-1:0]   u_r, u_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  grp_r, grp_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [ADDR_W-1:0] addr_a_r, addr_a_nxt;
  logic [ADDR_W-1:0] addr_b_r, addr_b_nxt;
  logic [DATA_W-1:0] x_r, x_nxt;
  logic [DATA_W-1:0] y_r, y_nxt;
  logic [DATA_W-1:0] hi_r, hi_nxt;
  logic [DATA_W-1:0] w_r, w_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_done_r, out_done_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              mul_start;
  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_b;
  logic              mul_busy;
  logic              mul_done;
  logic [DATA_W-1:0] mul_res;

  logic              in_acc;
  logic [CNT_W-1:0]  n_full;
  logic [CNT_W-1:0]  half;
  logic [CNT_W-1:0]  len;
  logic [ADDR_W-1:0] rev_full;
  logic [CNT_W-1:0]  rev_i;
  logic [LG_W-1:0]   lg_clamp;
  logic [DATA_W:0]   add_s;
  logic [DATA_W-1:0] add_m;
  logic [DATA_W-1:0] sub_m;
  logic [DATA_W-1:0] load_red;
  logic [CNT_W-1:0]  pos_a;

  ntt_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ntt_mulmod u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_res)
  );

  assign in_stall = (state_r != ST_IDLE) || rd_pend_r || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    n_full = CNT_W'(1) << lg_r;
    half   = CNT_W'(1) << (u_r - 1'b1);
    len    = half << 1;
    for (int b = 0; b < ADDR_W; b++) rev_full[b] = i_r[ADDR_W-1-b];
    rev_i  = CNT_W'(rev_full) >> (LG_W'(ADDR_W) - lg_r);
    pos_a  = grp_r + k_r;
    if (lsz_r == '0)
      lg_clamp = LG_W'(1);
    else if (LG_W'(lsz_r) > LG_W'(MAX_LOG_N))
      lg_clamp = LG_W'(MAX_LOG_N);
    else
      lg_clamp = LG_W'(lsz_r);
    add_s    = {1'b0, x_r} + {1'b0, hi_r};
    add_m    = (add_s >= {1'b0, PRIME}) ? DATA_W'(add_s - {1'b0, PRIME}) : add_s[DATA_W-1:0];
    sub_m    = (x_r >= hi_r) ? x_r - hi_r : x_r + (PRIME - hi_r);
    load_red = (in_value >= PRIME) ? in_value - PRIME : in_value;
  end

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    dir_nxt       = dir_r;
    lsz_nxt       = lsz_r;
    lg_nxt        = lg_r;
    u_nxt         = u_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    grp_nxt       = grp_r;
    k_nxt         = k_r;
    addr_a_nxt    = addr_a_r;
    addr_b_nxt    = addr_b_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    hi_nxt        = hi_r;
    w_nxt         = w_r;
    rd_pend_nxt   = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_done_nxt  = out_done_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_a_r;
    ram_wdata     = y_r;
    ram_raddr     = in_index[ADDR_W-1:0];
    mul_start     = 1'b0;
    mul_a         = ram_rdata;
    mul_b         = w_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_DIRECTION: dir_nxt = cfg_wdata[0];
        REG_LOG_SIZE:  lsz_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = ram_rdata;
      out_done_nxt  = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_operation)
            OP_LOAD: begin
              ram_we    = 1'b1;
              ram_waddr = in_index[ADDR_W-1:0];
              ram_wdata = load_red;
            end
            OP_READ: rd_pend_nxt = 1'b1;
            OP_RUN: begin
              lg_nxt    = lg_clamp;
              i_nxt     = '0;
              ph_nxt    = PH_BITREV;
              state_nxt = ST_NEXT;
            end
            default: ;
          endcase
        end
      end
      ST_NEXT: begin
        unique case (ph_r)
          PH_BITREV: begin
            if (i_r == n_full) begin
              ph_nxt  = PH_BFLY;
              u_nxt   = LG_W'(1);
              grp_nxt = '0;
              k_nxt   = '0;
              w_nxt   = DATA_W'(1);
            end else begin
              i_nxt = i_r + 1'b1;
              if (rev_i < i_r) begin
                addr_a_nxt = i_r[ADDR_W-1:0];
                addr_b_nxt = rev_i[ADDR_W-1:0];
                state_nxt  = ST_RD_A;
              end
            end
          end
          PH_BFLY: begin
            if (u_r > lg_r) begin
              if (dir_r) begin
                ph_nxt = PH_FLIP;
                i_nxt  = CNT_W'(1);
                j_nxt  = n_full - 1'b1;
              end else begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '0;
                out_done_nxt  = 1'b1;
                state_nxt     = ST_IDLE;
              end
            end else begin
              addr_a_nxt = pos_a[ADDR_W-1:0];
              addr_b_nxt = ADDR_W'(pos_a + half);
              state_nxt  = ST_RD_A;
            end
          end
          PH_FLIP: begin
            if (i_r < j_r) begin
              addr_a_nxt = i_r[ADDR_W-1:0];
              addr_b_nxt = j_r[ADDR_W-1:0];
              i_nxt      = i_r + 1'b1;
              j_nxt      = j_r - 1'b1;
              state_nxt  = ST_RD_A;
            end else begin
              ph_nxt = PH_SCALE;
              i_nxt  = '0;
            end
          end
          PH_SCALE: begin
            if (i_r == n_full) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_done_nxt  = 1'b1;
              state_nxt     = ST_IDLE;
            end else begin
              addr_a_nxt = i_r[ADDR_W-1:0];
              addr_b_nxt = i_r[ADDR_W-1:0];
              i_nxt      = i_r + 1'b1;
              state_nxt  = ST_RD_A;
            end
          end
          default: ;
        endcase
      end
      ST_RD_A: begin
        ram_raddr = addr_a_r;
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        ram_raddr = addr_b_r;
        x_nxt     = ram_rdata;
        state_nxt = ST_GET;
      end
      ST_GET: begin
        y_nxt = ram_rdata;
        if (ph_r == PH_BFLY) begin
          mul_start = 1'b1;
          mul_a     = ram_rdata;
          mul_b     = w_r;
          state_nxt = ST_MUL;
        end else if (ph_r == PH_SCALE) begin
          mul_start = 1'b1;
          mul_a     = x_r;
          mul_b     = INV_N[lg_r];
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_WR_A;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          hi_nxt    = mul_res;
          state_nxt = ST_WR_A;
        end
      end
      ST_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = addr_a_r;
        if (ph_r == PH_BFLY)
          ram_wdata = add_m;
        else if (ph_r == PH_SCALE)
          ram_wdata = hi_r;
        else
          ram_wdata = y_r;
        state_nxt = (ph_r == PH_SCALE) ? ST_NEXT : ST_WR_B;
      end
      ST_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b_r;
        ram_wdata = (ph_r == PH_BFLY) ? sub_m : x_r;
        state_nxt = ST_NEXT;
        if (ph_r == PH_BFLY) begin
          if (k_r + 1'b1 == half) begin
            k_nxt = '0;
            w_nxt = DATA_W'(1);
            if (grp_r + len == n_full) begin
              grp_nxt = '0;
              u_nxt   = u_r + 1'b1;
            end else begin
              grp_nxt = grp_r + len;
            end
          end else begin
            // next twiddle: w *= stage root
            k_nxt     = k_r + 1'b1;
            mul_start = 1'b1;
            mul_a     = w_r;
            mul_b     = ROOTS[u_r];
            state_nxt = ST_TW;
          end
        end
      end
      ST_TW: begin
        if (mul_done) begin
          w_nxt     = mul_res;
          state_nxt = ST_NEXT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_BITREV;
      dir_r       <= 1'b0;
      lsz_r       <= CFG_W'(10);
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      dir_r       <= dir_nxt;
      lsz_r       <= lsz_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lg_r       <= lg_nxt;
    u_r        <= u_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    grp_r      <= grp_nxt;
    k_r        <= k_nxt;
    addr_a_r   <= addr_a_nxt;
    addr_b_r   <= addr_b_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    hi_r       <= hi_nxt;
    w_r        <= w_nxt;
    out_data_r <= out_data_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;
  assign out_is_done = out_done_r;

  a_run_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_operation == OP_RUN |=> state_r != ST_IDLE)
    else $error("run request did not start the sequencer");

  a_read_returns: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |=> out_valid_r && !out_done_r)
    else $error("pending read produced no result");

  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_bfly_pair: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR_A && ph_r == PH_BFLY |-> addr_b_r == ADDR_W'(addr_a_r + half))
    else $error("butterfly pair addresses out of step");

endmodule
